FILE: rtl/rbd_pkg.sv
`timescale 1ns / 1ps

package rbd_pkg;

	localparam int DATA_W = 32;
	localparam int OCC_W  = 4;

	localparam logic signed [DATA_W-1:0] EMPTY_MARK = -32'sd10101010;

	typedef enum logic [1:0] {
		OP_PUSH_BACK  = 2'd0,
		OP_PUSH_FRONT = 2'd1,
		OP_POP_BACK   = 2'd2,
		OP_POP_FRONT  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// control from pointer logic to memory and result stage
	typedef struct packed {
		logic    wr_en;
		logic    rd_en;
		status_t status;
	} ctl_t;

endpackage

FILE: rtl/rbd_ram.sv
`timescale 1ns / 1ps

module rbd_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: rtl/rbd_ctrl.sv
`timescale 1ns / 1ps

module rbd_ctrl import rbd_pkg::*; #(
	parameter int DEPTH = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  func_t                      func,
	output ctl_t                       ctl,
	output logic [$clog2(DEPTH)-1:0]   addr,
	output logic [OCC_W-1:0]           occupancy,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	logic [AW-1:0] front_q, back_q, front_d, back_d;
	logic [CW-1:0] count_q, count_d;
	logic          full, empty;
	logic [CW+OCC_W-1:0] occ_ext;

	function automatic logic [AW-1:0] step_up(input logic [AW-1:0] p);
		return (p == LAST) ? '0 : p + AW'(1);
	endfunction

	function automatic logic [AW-1:0] step_down(input logic [AW-1:0] p);
		return (p == '0) ? LAST : p - AW'(1);
	endfunction

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);

	always_comb begin
		front_d    = front_q;
		back_d     = back_q;
		count_d    = count_q;
		addr       = front_q;
		ctl.wr_en  = 1'b0;
		ctl.rd_en  = 1'b0;
		ctl.status = ST_DONE;
		case (func)
			OP_PUSH_BACK: begin
				addr = back_q;
				if (full) begin
					ctl.status = ST_FULL;
				end else begin
					ctl.wr_en = accept;
					back_d    = step_up(back_q);
					count_d   = count_q + CW'(1);
				end
			end
			OP_PUSH_FRONT: begin
				addr = step_down(front_q);
				if (full) begin
					ctl.status = ST_FULL;
				end else begin
					ctl.wr_en = accept;
					front_d   = addr;
					count_d   = count_q + CW'(1);
				end
			end
			OP_POP_BACK: begin
				addr = step_down(back_q);
				if (empty) begin
					ctl.status = ST_EMPTY;
				end else begin
					ctl.rd_en = accept;
					back_d    = addr;
					count_d   = count_q - CW'(1);
				end
			end
			OP_POP_FRONT: begin
				addr = front_q;
				if (empty) begin
					ctl.status = ST_EMPTY;
				end else begin
					ctl.rd_en = accept;
					front_d   = step_up(front_q);
					count_d   = count_q - CW'(1);
				end
			end
			default: begin
				ctl.status = ST_DONE;
			end
		endcase
	end

	// occupancy field is 4 bits wide; count wraps into it
	assign occ_ext   = {{OCC_W{1'b0}}, count_d};
	assign occupancy = occ_ext[OCC_W-1:0];
	assign count     = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			front_q <= front_d;
			back_q  <= back_d;
			count_q <= count_d;
		end
	end

`ifndef SYNTHESIS
	logic [CW:0] ring_sum;
	logic [CW:0] ring_pos;
	assign ring_sum = {1'b0, count_q} + (CW+1)'(front_q);
	assign ring_pos = (ring_sum >= (CW+1)'(DEPTH)) ? ring_sum - (CW+1)'(DEPTH) : ring_sum;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("count above capacity");

	a_ring_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		ring_pos == (CW+1)'(back_q))
		else $error("front, back and count disagree");

	a_reject_holds: assert property (@(posedge clk) disable iff (!arst_n)
		accept && ctl.status != ST_DONE |=> $stable(count_q) && $stable(front_q)
			&& $stable(back_q))
		else $error("rejected operation changed state");
`endif

endmodule

FILE: rtl/ring_buffer_deque.sv
`timescale 1ns / 1ps

// Double-ended queue of key/value words in a ring of DEPTH slots.
// Input channel s_*: s_tuser carries the operation (push back, push front,
// pop back, pop front), s_tdata the key and value to push.
// Output channel m_*: one word per input word, in order, giving the popped
// key and value, the new occupancy, and in m_tuser the status (done, push
// rejected as full, pop rejected as empty).
// Pointers update and the memory read is issued at input accept; the
// registered read data and the word's status wait in stage s1 and move
// into the output register, which drives m_tvalid, once that register is
// free or being read.
// Throughput is one word per cycle unless the output stalls; each word needs
// a single memory access; pointer and count updates take effect at accept.
// When the receiver stalls, the output register and one in-flight stage
// hold their words and s_tready drops only when both are occupied.
// Reset clears the pointers, the count and both valid stages; slot contents
// are undefined until pushed. No clearing pass is needed.
module ring_buffer_deque import rbd_pkg::*; #(
	parameter int DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // in_key[31:0], in_value[63:32]
	input  logic [1:0]  s_tuser,   // func[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // out_key[31:0], out_value[63:32], occupancy[67:64]
	output logic [1:0]  m_tuser    // status[1:0]
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic                     accept;
	func_t                    func;
	logic signed [DATA_W-1:0] in_key, in_value;
	ctl_t                     ctl;
	logic [AW-1:0]            addr;
	logic [OCC_W-1:0]         occ_next;
	logic [CW-1:0]            count;
	logic [2*DATA_W-1:0]      rd_data;

	logic                     valid_s1, pop_ok_s1;
	status_t                  status_s1;
	logic [OCC_W-1:0]         occ_s1;
	logic                     adv_s1;

	logic                     out_valid_q;
	logic signed [DATA_W-1:0] key_q, value_q;
	status_t                  status_q;
	logic [OCC_W-1:0]         occ_q;

	assign func     = func_t'(s_tuser);
	assign in_key   = s_tdata[DATA_W-1:0];
	assign in_value = s_tdata[2*DATA_W-1:DATA_W];

	assign adv_s1   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;
	assign accept   = s_tvalid && s_tready;

	rbd_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.func      (func),
		.ctl       (ctl),
		.addr      (addr),
		.occupancy (occ_next),
		.count     (count)
	);

	rbd_ram #(.WIDTH(2 * DATA_W), .DEPTH(DEPTH)) u_ram (
		.clk     (clk),
		.wr_en   (ctl.wr_en),
		.wr_addr (addr),
		.wr_data ({in_value, in_key}),
		.rd_en   (ctl.rd_en),
		.rd_addr (addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pop_ok_s1 <= ctl.rd_en;
			status_s1 <= ctl.status;
			occ_s1    <= occ_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			status_q <= status_s1;
			occ_q    <= occ_s1;
			if (pop_ok_s1) begin
				key_q   <= rd_data[DATA_W-1:0];
				value_q <= rd_data[2*DATA_W-1:DATA_W];
			end else if (status_s1 == ST_EMPTY) begin
				key_q   <= EMPTY_MARK;
				value_q <= EMPTY_MARK;
			end else begin
				key_q   <= '0;
				value_q <= '0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, occ_q, value_q, key_q};
	assign m_tuser  = status_q;

`ifndef SYNTHESIS
	a_hold_stage: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1)
		else $error("in-flight word dropped while output stalled");

	a_no_accept_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !m_tready |-> !accept)
		else $error("input accepted with both stages full");

	a_empty_pop_status: assert property (@(posedge clk) disable iff (!arst_n)
		accept && count == '0 && (func == OP_POP_BACK || func == OP_POP_FRONT)
			|-> ctl.status == ST_EMPTY && !ctl.rd_en)
		else $error("pop from empty ring not rejected");
`endif

endmodule

FILE: sim/rbd_checker.sv
`timescale 1ns / 1ps

module rbd_checker import rbd_pkg::*; #(
	parameter int DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,   // in_key[31:0], in_value[63:32]
	input  logic [1:0]  s_tuser,   // func[1:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [71:0] m_tdata,   // out_key[31:0], out_value[63:32], occupancy[67:64]
	input  logic [1:0]  m_tuser,   // status[1:0]
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [DATA_W-1:0] key;
		logic [DATA_W-1:0] value;
		status_t           status;
		logic [OCC_W-1:0]  occ;
	} deque_result_t;

	logic [DATA_W-1:0] slot_keys [DEPTH];
	logic [DATA_W-1:0] slot_vals [DEPTH];
	int front_idx;
	int back_idx;
	int held;
	int mismatches;
	deque_result_t op_results_q [$];

	// updates the shadow deque and returns the word the block should send back
	function automatic deque_result_t apply_deque_op(func_t f, logic [DATA_W-1:0] k,
			logic [DATA_W-1:0] v);
		deque_result_t r;
		int slot;
		r.key    = '0;
		r.value  = '0;
		r.status = ST_DONE;
		if (f == OP_PUSH_BACK || f == OP_PUSH_FRONT) begin
			if (held >= DEPTH) begin
				r.status = ST_FULL;
			end else begin
				if (f == OP_PUSH_BACK) begin
					slot = back_idx;
					back_idx = (slot + 1) % DEPTH;
				end else begin
					slot = (front_idx + DEPTH - 1) % DEPTH;
					front_idx = slot;
				end
				slot_keys[slot] = k;
				slot_vals[slot] = v;
				held++;
			end
		end else begin
			if (held == 0) begin
				r.status = ST_EMPTY;
				r.key    = EMPTY_MARK;
				r.value  = EMPTY_MARK;
			end else begin
				if (f == OP_POP_BACK) begin
					slot = (back_idx + DEPTH - 1) % DEPTH;
					back_idx = slot;
				end else begin
					slot = front_idx;
					front_idx = (slot + 1) % DEPTH;
				end
				r.key   = slot_keys[slot];
				r.value = slot_vals[slot];
				held--;
			end
		end
		r.occ = held[OCC_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		deque_result_t exp_r;
		deque_result_t got_r;
		if (!arst_n) begin
			front_idx = 0;
			back_idx  = 0;
			held      = 0;
			mismatches = 0;
			op_results_q.delete();
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_r.key    = m_tdata[31:0];
				got_r.value  = m_tdata[63:32];
				got_r.occ    = m_tdata[67:64];
				got_r.status = status_t'(m_tuser);
				if (op_results_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected word: key %h value %h status %0d occ %0d",
							got_r.key, got_r.value, got_r.status, got_r.occ);
				end else begin
					exp_r = op_results_q[0];
					op_results_q.delete(0);
					if (got_r.key !== exp_r.key || got_r.value !== exp_r.value ||
							got_r.status !== exp_r.status || got_r.occ !== exp_r.occ) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp %h %h %0d %0d, got %h %h %0d %0d",
								exp_r.key, exp_r.value, exp_r.status, exp_r.occ,
								got_r.key, got_r.value, got_r.status, got_r.occ);
					end
				end
			end
			if (s_tvalid && s_tready)
				op_results_q.insert(op_results_q.size(),
					apply_deque_op(func_t'(s_tuser), s_tdata[31:0], s_tdata[63:32]));
			fail_count <= mismatches;
			pending    <= op_results_q.size();
		end
	end

endmodule

FILE: sim/tb_ring_buffer_deque.sv
`timescale 1ns / 1ps

module tb_ring_buffer_deque;
	import rbd_pkg::*;

	localparam int DEPTH      = 8;
	localparam int IDLE_LIMIT = 5000;
	localparam int RAND_ITEMS = 750;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;   // in_key[31:0], in_value[63:32]
	logic [1:0]  s_tuser = '0;   // func[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;        // out_key[31:0], out_value[63:32], occupancy[67:64]
	logic [1:0]  m_tuser;        // status[1:0]
	int          fail_count;
	int          pending;
	int          idle_cycles = 0;
	int          burst_left = 4;
	int          stall_mode = 0;
	int          stall_left = 0;
	int          stall_tick = 0;

	ring_buffer_deque #(.DEPTH(DEPTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	rbd_checker #(.DEPTH(DEPTH)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// receiver: stretches of full rate, random stalls and a one-in-four pattern
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_left <= $urandom_range(20, 200);
		end else begin
			stall_left <= stall_left - 1;
		end
		stall_tick <= stall_tick + 1;
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			default: m_tready <= (stall_tick % 4 == 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	// holds the word until accepted, then maybe drops valid for a gap
	task automatic send_word(func_t f, logic [31:0] k, logic [31:0] v);
		s_tvalid <= 1'b1;
		s_tuser  <= f;
		s_tdata  <= {v, k};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
				: $urandom_range(1, 16);
		end
	endtask

	initial begin
		int    i;
		int    phase_left;
		bit    fill_mode;
		bit    is_push;
		func_t f;
		phase_left = 0;
		fill_mode  = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty pops, fill to full (first four words extreme), rejected pushes, drain, empty pop
		send_word(OP_POP_FRONT, 32'h1234_5678, 32'h9abc_def0);
		send_word(OP_POP_BACK, 32'hffff_ffff, 32'hffff_ffff);
		send_word(OP_PUSH_BACK, 32'h8000_0000, 32'h7fff_ffff);
		send_word(OP_PUSH_FRONT, 32'h7fff_ffff, 32'h8000_0000);
		send_word(OP_PUSH_BACK, 32'hffff_ffff, 32'h0000_0000);
		send_word(OP_PUSH_FRONT, 32'h0000_0000, 32'hffff_ffff);
		for (i = 4; i < DEPTH; i++)
			send_word((i % 2) ? OP_PUSH_FRONT : OP_PUSH_BACK, $urandom, $urandom);
		send_word(OP_PUSH_BACK, 32'hdead_beef, 32'hcafe_f00d);
		send_word(OP_PUSH_FRONT, 32'h5555_5555, 32'haaaa_aaaa);
		for (i = 0; i < DEPTH; i++)
			send_word((i % 2) ? OP_POP_FRONT : OP_POP_BACK, $urandom, $urandom);
		send_word(OP_POP_FRONT, 32'h0, 32'h0);

		// random part: random fill-leaning and drain-leaning phases to hit both ends
		for (i = 0; i < RAND_ITEMS; i++) begin
			if (phase_left == 0) begin
				fill_mode  = 1'($urandom_range(0, 1));
				phase_left = $urandom_range(8, 40);
			end
			phase_left--;
			is_push = ($urandom_range(0, 3) != 0) ? fill_mode : !fill_mode;
			if (is_push)
				f = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
			else
				f = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
			send_word(f, pick_word(), pick_word());
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/rbd_pkg.sv
rtl/rbd_ram.sv
rtl/rbd_ctrl.sv
rtl/ring_buffer_deque.sv
sim/rbd_checker.sv
sim/tb_ring_buffer_deque.sv
